FILE: src/u2g_pkg.sv
// ----------------------------------------------------------------------------
// u2g_pkg
// Shared types, constants and glyph lookup tables for the UTF-8 to glyph code
// transcoder.
// ----------------------------------------------------------------------------
package u2g_pkg;

  // Glyph codes
  localparam logic [7:0] GlyphChecker = 8'd127;
  localparam logic [7:0] GlyphSpace   = 8'd32;
  localparam logic [7:0] GlyphNone    = 8'd0;
  localparam logic [7:0] GlyphEmoji   = 8'd129;
  localparam logic [7:0] C3Offset     = 8'd64;

  // Lead and control byte codes
  localparam logic [7:0] ByteNul  = 8'h00;
  localparam logic [7:0] ByteLf   = 8'h0A;
  localparam logic [7:0] ByteCtlEnd = 8'h20;
  localparam logic [7:0] LeadC2   = 8'hC2;
  localparam logic [7:0] LeadC3   = 8'hC3;
  localparam logic [7:0] LeadC4   = 8'hC4;
  localparam logic [7:0] LeadC5   = 8'hC5;
  localparam logic [7:0] LeadE2   = 8'hE2;
  localparam logic [7:0] LeadF0   = 8'hF0;

  // Lead class masks
  localparam logic [7:0] Mask2 = 8'b1110_0000;
  localparam logic [7:0] Pat2  = 8'b1100_0000;
  localparam logic [7:0] Mask3 = 8'b1111_0000;
  localparam logic [7:0] Pat3  = 8'b1110_0000;
  localparam logic [7:0] Mask4 = 8'b1111_1000;
  localparam logic [7:0] Pat4  = 8'b1111_0000;

  // Four-byte emoji sequence continuation bytes
  localparam logic [7:0] F0Cont1 = 8'h9F;
  localparam logic [7:0] F0Cont2 = 8'h90;
  localparam logic [7:0] F0Cont3 = 8'hB1;

  // Euro sign and general punctuation prefixes for E2 sequences
  localparam logic [7:0] E2Euro1 = 8'h82;
  localparam logic [7:0] E2Euro2 = 8'hAC;
  localparam logic [7:0] E2Punct = 8'h80;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'd0,
    MODE_RUN  = 4'd1,
    MODE_SKIP = 4'd2,
    MODE_C2   = 4'd3,
    MODE_C3   = 4'd4,
    MODE_C4   = 4'd5,
    MODE_C5   = 4'd6,
    MODE_E2A  = 4'd7,
    MODE_E2B  = 4'd8,
    MODE_F0A  = 4'd9,
    MODE_F0B  = 4'd10,
    MODE_F0C  = 4'd11
  } mode_e;

  // What one input byte produces: count copies of one glyph
  typedef struct packed {
    logic [7:0] glyph;
    logic       glyph_valid;
    logic       end_of_text;
    logic [1:0] count;
  } dec_res_t;

  // Outcome of decoding a byte as a lead byte
  typedef struct packed {
    logic [7:0] glyph;
    logic [1:0] count;
    mode_e      mode;
    logic [1:0] skip;
  } lead_t;

  function automatic logic [7:0] map_c2(input logic [7:0] c);
    logic [7:0] g;
    case (c)
      8'h86:   g = 8'd134;
      8'h87:   g = 8'd135;
      8'h89:   g = 8'd137;
      8'hA0:   g = 8'd129;
      8'hA7:   g = 8'd167;
      8'hB0:   g = 8'd176;
      8'hB1:   g = 8'd177;
      8'hB2:   g = 8'd178;
      8'hB3:   g = 8'd179;
      8'hB5:   g = 8'd181;
      8'hB9:   g = 8'd185;
      8'hBA:   g = 8'd186;
      default: g = GlyphChecker;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] map_c4(input logic [7:0] c);
    logic [7:0] g;
    case (c)
      8'h8C:   g = 8'd142;
      8'h8D:   g = 8'd157;
      default: g = GlyphChecker;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] map_c5(input logic [7:0] c);
    logic [7:0] g;
    case (c)
      8'hA0:   g = 8'd138;
      8'hA1:   g = 8'd154;
      8'hBD:   g = 8'd143;
      8'hBE:   g = 8'd158;
      default: g = GlyphChecker;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] map_e2(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] g;
    g = GlyphChecker;
    if (a == E2Euro1 && b == E2Euro2) begin
      g = 8'd128;
    end else if (a == E2Punct) begin
      case (b)
        8'h93:   g = 8'd150;
        8'h94:   g = 8'd151;
        8'hA2:   g = 8'd183;
        8'hA6:   g = 8'd133;
        8'hB0:   g = 8'd137;
        default: g = GlyphChecker;
      endcase
    end
    return g;
  endfunction

  // Classify a byte seen while waiting for a lead byte
  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t r;
    r.glyph = GlyphChecker;
    r.count = 2'd0;
    r.mode  = MODE_IDLE;
    r.skip  = 2'd0;
    if (!b[7]) begin
      r.count = 2'd1;
      if (b == ByteNul || b == ByteLf) begin
        r.glyph = GlyphSpace;
      end else if (b < ByteCtlEnd) begin
        r.glyph = GlyphChecker;
      end else begin
        r.glyph = b;
      end
    end else if ((b & Mask2) == Pat2) begin
      if (b == LeadC2) begin
        r.mode = MODE_C2;
      end else if (b == LeadC3) begin
        r.mode = MODE_C3;
      end else if (b == LeadC4) begin
        r.mode = MODE_C4;
      end else if (b == LeadC5) begin
        r.mode = MODE_C5;
      end else begin
        r.count = 2'd1;
        r.mode  = MODE_SKIP;
        r.skip  = 2'd1;
      end
    end else if ((b & Mask3) == Pat3) begin
      if (b == LeadE2) begin
        r.mode = MODE_E2A;
      end else begin
        r.count = 2'd2;
        r.mode  = MODE_SKIP;
        r.skip  = 2'd2;
      end
    end else if ((b & Mask4) == Pat4) begin
      if (b == LeadF0) begin
        r.mode = MODE_F0A;
      end else begin
        r.count = 2'd3;
        r.mode  = MODE_SKIP;
        r.skip  = 2'd3;
      end
    end else begin
      r.mode = MODE_RUN;
    end
    return r;
  endfunction

endpackage

FILE: src/utf8_to_glyph_code_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_glyph_code_transcoder
// Converts a UTF-8 byte stream into 8-bit display glyph codes, zero to three
// results per byte, with end of message flushing.
// ----------------------------------------------------------------------------
//  Channel | Handshake               | Payload
//  --------+-------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o | in_byte_i, last_byte_i
//  out     | out_valid_o/out_stall_i | glyph_o, glyph_valid_o, end_of_text_o,
//          |                         | run_last_o
//
// A byte is decoded in the cycle it is accepted and its results appear in the
// result register on the next cycle. A byte yielding one result or none can be
// followed in the next cycle unless the output stalls; a byte yielding more
// results holds the result register, and the input is stalled until its last copy leaves.
// Reset puts the decoder in its idle state and empties the result register.
// ----------------------------------------------------------------------------
module utf8_to_glyph_code_transcoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] glyph_o,
  output logic       glyph_valid_o,
  output logic       end_of_text_o,
  output logic       run_last_o
);

  u2g_pkg::dec_res_t dec_res;
  logic              emit_free;
  logic              in_accept;

  assign in_stall_o = !emit_free;
  assign in_accept  = in_valid_i && emit_free;

  // Decode the byte stream
  u2g_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .res_o       (dec_res)
  );

  // Register and repeat results
  u2g_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_accept),
    .res_i         (dec_res),
    .free_o        (emit_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .glyph_o       (glyph_o),
    .glyph_valid_o (glyph_valid_o),
    .end_of_text_o (end_of_text_o),
    .run_last_o    (run_last_o)
  );

  // An end marker only ever closes a message
  a_marker_ends_text : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !glyph_valid_o) |-> (end_of_text_o && glyph_o == u2g_pkg::GlyphNone))
    else $error("end marker outside end of text");

  // A new byte only enters when no item is pending or the pending item is finishing
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (!out_valid_o || (run_last_o && !out_stall_i)))
    else $error("byte accepted over pending results");

  // The end of a message is always the last copy of its byte
  a_eot_run_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_text_o) |-> run_last_o)
    else $error("end of text before last copy");

  // A copy that is not the last is followed by another copy
  a_copy_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !run_last_o) |=> out_valid_o)
    else $error("copies of an item lost");

endmodule

FILE: src/u2g_decoder.sv
// ----------------------------------------------------------------------------
// u2g_decoder
// Holds the sequence state and turns each accepted byte into a glyph code and
// the number of times it is to be emitted.
// ----------------------------------------------------------------------------
module u2g_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               last_byte_i,
  output u2g_pkg::dec_res_t  res_o
);

  u2g_pkg::mode_e mode_q, mode_d;
  logic [7:0]     first_cont_q, first_cont_d;
  logic [7:0]     second_cont_q, second_cont_d;
  logic [1:0]     skip_q, skip_d;

  // Decode the byte against the current sequence state
  always_comb begin
    u2g_pkg::lead_t lead;
    logic [7:0]     glyph;
    logic [1:0]     count;
    u2g_pkg::mode_e mode_n;
    logic [1:0]     skip_n;

    lead          = u2g_pkg::lead_decode(in_byte_i);
    glyph         = u2g_pkg::GlyphChecker;
    count         = 2'd0;
    mode_n        = u2g_pkg::MODE_IDLE;
    skip_n        = skip_q;
    first_cont_d  = first_cont_q;
    second_cont_d = second_cont_q;

    case (mode_q)
      u2g_pkg::MODE_RUN: begin
        if (in_byte_i[7]) begin
          count  = 2'd1;
          mode_n = u2g_pkg::MODE_RUN;
        end else begin
          glyph  = lead.glyph;
          count  = lead.count;
          mode_n = lead.mode;
          if (lead.mode == u2g_pkg::MODE_SKIP) begin
            skip_n = lead.skip;
          end
        end
      end
      u2g_pkg::MODE_SKIP: begin
        skip_n = skip_q - 2'd1;
        mode_n = (skip_n == 2'd0) ? u2g_pkg::MODE_IDLE : u2g_pkg::MODE_SKIP;
      end
      u2g_pkg::MODE_C2: begin
        glyph = u2g_pkg::map_c2(in_byte_i);
        count = 2'd1;
      end
      u2g_pkg::MODE_C3: begin
        glyph = in_byte_i + u2g_pkg::C3Offset;
        count = 2'd1;
      end
      u2g_pkg::MODE_C4: begin
        glyph = u2g_pkg::map_c4(in_byte_i);
        count = 2'd1;
      end
      u2g_pkg::MODE_C5: begin
        glyph = u2g_pkg::map_c5(in_byte_i);
        count = 2'd1;
      end
      u2g_pkg::MODE_E2A: begin
        first_cont_d = in_byte_i;
        mode_n       = u2g_pkg::MODE_E2B;
      end
      u2g_pkg::MODE_E2B: begin
        glyph = u2g_pkg::map_e2(first_cont_q, in_byte_i);
        count = 2'd1;
      end
      u2g_pkg::MODE_F0A: begin
        first_cont_d = in_byte_i;
        mode_n       = u2g_pkg::MODE_F0B;
      end
      u2g_pkg::MODE_F0B: begin
        second_cont_d = in_byte_i;
        mode_n        = u2g_pkg::MODE_F0C;
      end
      u2g_pkg::MODE_F0C: begin
        count = 2'd1;
        if (first_cont_q == u2g_pkg::F0Cont1 && second_cont_q == u2g_pkg::F0Cont2
            && in_byte_i == u2g_pkg::F0Cont3) begin
          glyph = u2g_pkg::GlyphEmoji;
        end
      end
      default: begin
        glyph  = lead.glyph;
        count  = lead.count;
        mode_n = lead.mode;
        if (lead.mode == u2g_pkg::MODE_SKIP) begin
          skip_n = lead.skip;
        end
      end
    endcase

    // Flush a sequence cut off by the end of the message
    res_o.glyph       = glyph;
    res_o.glyph_valid = 1'b1;
    res_o.end_of_text = last_byte_i;
    res_o.count       = count;
    if (last_byte_i) begin
      case (mode_n)
        u2g_pkg::MODE_C2, u2g_pkg::MODE_C3, u2g_pkg::MODE_C4, u2g_pkg::MODE_C5: begin
          res_o.glyph = u2g_pkg::GlyphChecker;
          res_o.count = 2'd1;
        end
        u2g_pkg::MODE_E2A, u2g_pkg::MODE_E2B: begin
          res_o.glyph = u2g_pkg::GlyphChecker;
          res_o.count = 2'd2;
        end
        u2g_pkg::MODE_F0A, u2g_pkg::MODE_F0B, u2g_pkg::MODE_F0C: begin
          res_o.glyph = u2g_pkg::GlyphChecker;
          res_o.count = 2'd3;
        end
        default: begin
          // End marker when the final byte yields no glyph
          if (count == 2'd0) begin
            res_o.glyph       = u2g_pkg::GlyphNone;
            res_o.glyph_valid = 1'b0;
            res_o.count       = 2'd1;
          end
        end
      endcase
      mode_d        = u2g_pkg::MODE_IDLE;
      skip_d        = 2'd0;
      first_cont_d  = 8'd0;
      second_cont_d = 8'd0;
    end else begin
      mode_d = mode_n;
      skip_d = skip_n;
    end
  end

  // Advance the sequence state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= u2g_pkg::MODE_IDLE;
      skip_q        <= 2'd0;
      first_cont_q  <= 8'd0;
      second_cont_q <= 8'd0;
    end else if (accept_i) begin
      mode_q        <= mode_d;
      skip_q        <= skip_d;
      first_cont_q  <= first_cont_d;
      second_cont_q <= second_cont_d;
    end
  end

endmodule

FILE: src/u2g_emitter.sv
// ----------------------------------------------------------------------------
// u2g_emitter
// Result register: holds one decoded glyph and repeats it as many times as
// the byte calls for, marking the last copy.
// ----------------------------------------------------------------------------
module u2g_emitter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  u2g_pkg::dec_res_t  res_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         glyph_o,
  output logic               glyph_valid_o,
  output logic               end_of_text_o,
  output logic               run_last_o
);

  logic [1:0] remain_q, remain_d;
  logic [7:0] glyph_q;
  logic       glyph_valid_q;
  logic       eot_q;
  logic       take;

  assign take   = out_valid_o && !out_stall_i;
  // Room for a new item when empty or once the last copy leaves this cycle
  assign free_o = (remain_q == 2'd0) || (remain_q == 2'd1 && take);

  // Count down the copies still to deliver
  always_comb begin
    remain_d = remain_q;
    if (load_i) begin
      remain_d = res_i.count;
    end else if (take) begin
      remain_d = remain_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= 2'd0;
    end else begin
      remain_q <= remain_d;
    end
  end

  // Hold the payload of the current item
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      glyph_q       <= res_i.glyph;
      glyph_valid_q <= res_i.glyph_valid;
      eot_q         <= res_i.end_of_text;
    end
  end

  assign out_valid_o   = (remain_q != 2'd0);
  assign glyph_o       = glyph_q;
  assign glyph_valid_o = glyph_valid_q;
  assign run_last_o    = (remain_q == 2'd1);
  assign end_of_text_o = eot_q && (remain_q == 2'd1);

endmodule
